@@ hdl/pbd_pkg.sv @@
// shared types, character codes and symbol decode for the pem base64 decoder
// no dependencies
`timescale 1ns / 1ps

package pbd_pkg;

    localparam int COUNT_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int REPORT_BITS     = 16;
    localparam int CAP_BITS        = 16;
    localparam int MAX_BYTES       = 3;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 16'hFFFF;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_PAD  = 8'h3D;
    localparam logic [7:0] CH_DASH = 8'h2D;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_PAD  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } sym_t;

    // one queue entry: the results caused by one accepted character
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0]             data;
        logic [MAX_BYTES-1:0][REPORT_BITS-1:0] count;
        logic [1:0]                            n_bytes;
        logic                                  has_status;
        status_t                               status;
        logic [REPORT_BITS-1:0]                final_count;
    } job_t;

    function automatic sym_t sym_decode(input logic [7:0] c);
        sym_t       r;
        logic [7:0] d;
        r = '0;
        d = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            d = c - 8'h41;
            r.valid = 1'b1;
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            d = c - 8'h61 + 8'd26;
            r.valid = 1'b1;
        end else if (c >= 8'h30 && c <= 8'h39) begin
            d = c - 8'h30 + 8'd52;
            r.valid = 1'b1;
        end else if (c == CH_PLUS) begin
            d = 8'd62;
            r.valid = 1'b1;
        end else if (c == CH_SLASH) begin
            d = 8'd63;
            r.valid = 1'b1;
        end
        r.value = d[5:0];
        return r;
    endfunction

endpackage

@@ hdl/pbd_front.sv @@
// front end: line filtering, symbol grouping, error and byte count tracking
// depends on pbd_pkg
`timescale 1ns / 1ps

module pbd_front
    import pbd_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic [7:0]          char_in,
    input  logic                is_last,
    input  logic [CAP_BITS-1:0] capacity,
    output logic                push,
    output job_t                job
);

    localparam int CMP_W = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_LIM = {COUNT_BITS{1'b1}};
    localparam logic [CMP_W-1:0] REP_MAX = CMP_W'({REPORT_BITS{1'b1}});

    logic                  line_start_reg, line_start_next;
    logic                  skipping_reg, skipping_next;
    logic [17:0]           accum_reg, accum_next;
    logic [1:0]            pos_reg, pos_next;
    logic                  pad3_reg, pad3_next;
    status_t               err_reg, err_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    function automatic logic [REPORT_BITS-1:0] report(input logic [COUNT_BITS-1:0] c);
        logic [CMP_W-1:0] e;
        e = CMP_W'(c);
        return (e > REP_MAX) ? {REPORT_BITS{1'b1}} : e[REPORT_BITS-1:0];
    endfunction

    always_comb
    begin
        sym_t        dec;
        logic        drop;
        logic        take;
        logic        pad;
        logic [23:0] grp;
        logic [1:0]  n_grp;
        line_start_next = line_start_reg;
        skipping_next   = skipping_reg;
        accum_next      = accum_reg;
        pos_next        = pos_reg;
        pad3_next       = pad3_reg;
        err_next        = err_reg;
        cnt_next        = cnt_reg;
        dec   = sym_decode(char_in);
        drop  = 1'b0;
        take  = 1'b0;
        pad   = 1'b0;
        grp   = '0;
        n_grp = 2'd0;
        job   = '0;

        // line handling and character class
        if (char_in == CH_LF) begin
            line_start_next = 1'b1;
            skipping_next   = 1'b0;
        end else begin
            if (line_start_reg) begin
                line_start_next = 1'b0;
                if (char_in == CH_DASH) begin
                    skipping_next = 1'b1;
                    drop = 1'b1;
                end
            end else if (skipping_reg) begin
                drop = 1'b1;
            end
            if (char_in == CH_SP || char_in == CH_CR || char_in == CH_TAB) begin
                drop = 1'b1;
            end
            if (!drop) begin
                if (char_in == CH_PAD) begin
                    take = 1'b1;
                    pad  = 1'b1;
                end else if (dec.valid) begin
                    take = 1'b1;
                end else if (err_next == ST_OK) begin
                    err_next = ST_BAD_CHAR;
                end
            end
        end

        // grouping of sextets
        if (take && err_next == ST_OK) begin
            case (pos_reg)
                2'd0:
                begin
                    if (pad) begin
                        err_next = ST_BAD_PAD;
                    end else begin
                        accum_next = {12'd0, dec.value};
                        pos_next   = 2'd1;
                    end
                end
                2'd1:
                begin
                    if (pad) begin
                        err_next = ST_BAD_PAD;
                    end else begin
                        accum_next = {accum_reg[11:0], dec.value};
                        pos_next   = 2'd2;
                    end
                end
                2'd2:
                begin
                    if (pad) begin
                        pad3_next  = 1'b1;
                        accum_next = {accum_reg[11:0], 6'd0};
                    end else begin
                        accum_next = {accum_reg[11:0], dec.value};
                    end
                    pos_next = 2'd3;
                end
                default:
                begin
                    if (pad3_reg && !pad) begin
                        err_next = ST_BAD_PAD;
                    end else begin
                        grp   = {accum_reg, (pad ? 6'd0 : dec.value)};
                        n_grp = pad3_reg ? 2'd1 : (pad ? 2'd2 : 2'd3);
                        accum_next = '0;
                        pos_next   = 2'd0;
                        pad3_next  = 1'b0;
                    end
                end
            endcase
        end

        // end of text: pad out a partial group
        if (is_last && err_next == ST_OK) begin
            case (pos_next)
                2'd1:    err_next = ST_BAD_PAD;
                2'd2:
                begin
                    grp   = {accum_next[11:0], 12'd0};
                    n_grp = 2'd1;
                end
                2'd3:
                begin
                    grp   = {accum_next, 6'd0};
                    n_grp = pad3_next ? 2'd1 : 2'd2;
                end
                default: ;
            endcase
        end

        // byte emission with capacity check
        for (int i = 0; i < MAX_BYTES; i++) begin
            if (2'(i) < n_grp && err_next == ST_OK) begin
                if (CMP_W'(cnt_next) >= CMP_W'(capacity)) begin
                    err_next = ST_OVERFLOW;
                end else begin
                    if (cnt_next != CNT_LIM) begin
                        cnt_next = cnt_next + 1'b1;
                    end
                    job.n_bytes  = 2'(i + 1);
                    job.data[i]  = grp[23 - 8*i -: 8];
                    job.count[i] = report(cnt_next);
                end
            end
        end

        job.has_status  = is_last;
        job.status      = is_last ? err_next : ST_OK;
        job.final_count = is_last ? report(cnt_next) : '0;

        if (is_last) begin
            line_start_next = 1'b1;
            skipping_next   = 1'b0;
            accum_next      = '0;
            pos_next        = 2'd0;
            pad3_next       = 1'b0;
            err_next        = ST_OK;
            cnt_next        = '0;
        end

        push = accept && (job.n_bytes != 2'd0 || is_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            line_start_reg <= 1'b1;
            skipping_reg   <= 1'b0;
            accum_reg      <= '0;
            pos_reg        <= 2'd0;
            pad3_reg       <= 1'b0;
            err_reg        <= ST_OK;
            cnt_reg        <= '0;
        end else if (accept) begin
            line_start_reg <= line_start_next;
            skipping_reg   <= skipping_next;
            accum_reg      <= accum_next;
            pos_reg        <= pos_next;
            pad3_reg       <= pad3_next;
            err_reg        <= err_next;
            cnt_reg        <= cnt_next;
        end
    end

endmodule

@@ hdl/pbd_queue.sv @@
// small register queue of jobs between the front end and the result serializer
// depends on pbd_pkg
`timescale 1ns / 1ps

module pbd_queue
    import pbd_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  job_t wr_data,
    output logic full,
    input  logic rd_en,
    output job_t rd_data,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full    = (fill_reg == CNT_W'(DEPTH));
    assign empty   = (fill_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr_en) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            fill_next = fill_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/pbd_back.sv @@
// back end: walks each job's results out through a registered output stage
// depends on pbd_pkg
`timescale 1ns / 1ps

module pbd_back
    import pbd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  job_t                   job,
    input  logic                   job_valid,
    output logic                   job_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             data_byte,
    output logic                   has_data,
    output logic                   run_last,
    output logic                   message_end,
    output status_t                status,
    output logic [REPORT_BITS-1:0] byte_count
);

    logic [1:0]             idx_reg, idx_next;
    logic                   valid_reg;
    logic [7:0]             byte_reg;
    logic                   has_reg, last_reg, end_reg;
    status_t                status_reg;
    logic [REPORT_BITS-1:0] count_reg;

    logic       load;
    logic       is_byte;
    logic       is_final;
    logic [2:0] total;

    assign total    = {1'b0, job.n_bytes} + {2'b00, job.has_status};
    assign is_byte  = (idx_reg < job.n_bytes);
    assign is_final = ({1'b0, idx_reg} + 3'd1 == total);
    assign load     = job_valid && (!valid_reg || out_ready);
    assign job_pop  = load && is_final;
    assign idx_next = is_final ? 2'd0 : idx_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                idx_reg   <= idx_next;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            byte_reg   <= is_byte ? job.data[idx_reg] : 8'd0;
            has_reg    <= is_byte;
            last_reg   <= is_final;
            end_reg    <= !is_byte;
            status_reg <= is_byte ? ST_OK : job.status;
            count_reg  <= is_byte ? job.count[idx_reg] : job.final_count;
        end
    end

    assign out_valid   = valid_reg;
    assign data_byte   = byte_reg;
    assign has_data    = has_reg;
    assign run_last    = last_reg;
    assign message_end = end_reg;
    assign status      = status_reg;
    assign byte_count  = count_reg;

endmodule

@@ hdl/pem_base64_decoder_unit.sv @@
// pem base64 decoder: one text character per transfer, decoded bytes and a final status out
// throughput: one character per cycle in while the queue has room; one result per cycle
// out while m_tready is high, set by the output register, so four symbols (three bytes)
// keep up with a character a cycle; results are queued, then go to the output register
// reset (rst_n low, async): queue emptied, line and group state cleared, capacity back to 65535
// depends on pbd_pkg, pbd_front, pbd_queue, pbd_back
`timescale 1ns / 1ps

module pem_base64_decoder_unit
    import pbd_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration: out_capacity
    input  logic                cfg_wr_en,
    input  logic [CAP_BITS-1:0] cfg_wr_data,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,   // [7:0] char_in
    input  logic                s_tlast,   // is_last
    // output stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // [7:0] data_byte, [9:8] status, [25:10] byte_count
    output logic                m_tlast,   // run_last
    output logic [1:0]          m_tuser    // [0] has_data, [1] message_end
);

    // capacity register, written only while the block is idle: a user rule, not enforced here
    logic [CAP_BITS-1:0] capacity_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_wr_en) begin
            capacity_reg <= cfg_wr_data;
        end
    end

    logic    accept;
    logic    push;
    job_t    job_in;
    job_t    job_out;
    logic    q_full;
    logic    q_empty;
    logic    pop;

    logic [7:0]             data_byte;
    logic                   has_data;
    logic                   message_end;
    status_t                status;
    logic [REPORT_BITS-1:0] byte_count;

    // the front end takes a character whenever the queue has room
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    pbd_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .char_in  (s_tdata),
        .is_last  (s_tlast),
        .capacity (capacity_reg),
        .push     (push),
        .job      (job_in)
    );

    // decouples the per-character work from result delivery
    pbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data (job_in),
        .full    (q_full),
        .rd_en   (pop),
        .rd_data (job_out),
        .empty   (q_empty)
    );

    // one result per output transfer, bytes first then the status item
    pbd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job_out),
        .job_valid   (!q_empty),
        .job_pop     (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .data_byte   (data_byte),
        .has_data    (has_data),
        .run_last    (m_tlast),
        .message_end (message_end),
        .status      (status),
        .byte_count  (byte_count)
    );

    assign m_tdata = {6'd0, byte_count, status, data_byte};
    assign m_tuser = {message_end, has_data};

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for pem_base64_decoder_unit: directed rows, then random pem text
// checks every output transfer against an in-bench decoder model; depends on pbd_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
    import pbd_pkg::*;

    localparam int N_DIRECTED   = 25;
    localparam int NUM_PHASES   = 8;
    localparam int PHASE_ITEMS  = 32;     // characters per capacity setting, roughly
    localparam int DRAIN_CYCLES = 8;      // settle time after the last result
    localparam int HOLD_CYCLES  = 300;    // one long receiver stall to back the block up
    localparam int IDLE_PCT     = 18;

    localparam logic [7:0] CH_NUL = 8'h00;

    // one expected or observed output transfer
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_data;
        logic        run_last;
        logic        message_end;
        logic [1:0]  status;
        logic [15:0] byte_count;
    } pem_result_t;

    // one directed row; typed rows carry the status transfer's expected status and count
    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        logic        typed;
        logic [1:0]  st;
        logic [15:0] cnt;
    } stim_row_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CAP_BITS-1:0] cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = '0;     // [7:0] char_in
    logic                s_tlast = 1'b0;   // is_last
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [31:0]         m_tdata;          // [7:0] data_byte, [9:8] status, [25:10] byte_count
    logic                m_tlast;          // run_last
    logic [1:0]          m_tuser;          // [0] has_data, [1] message_end

    // 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    pem_base64_decoder_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // ---------------------------------------------------------------
    // decoder model state, mirrors the block after reset
    // ---------------------------------------------------------------
    logic          line_start = 1'b1;
    logic          skipping   = 1'b0;
    logic [17:0]   accum      = '0;
    logic [1:0]    group_pos  = '0;
    logic          pad3       = 1'b0;
    status_t       fault      = ST_OK;
    logic [15:0]   emitted    = '0;
    logic [15:0]   capacity   = CAP_RESET;

    pem_result_t   step_q[$];           // results of the character being modeled
    pem_result_t   pending_results[$];  // decoded bytes and statuses not yet seen on the output

    logic [7:0]    msg_chars[$];        // current random message

    int failures      = 0;
    int results_seen  = 0;
    int bytes_checked = 0;
    int status_seen   = 0;
    int faults_seen   = 0;
    int chars_sent    = 0;
    int messages_sent = 0;
    int cap_settings  = 0;
    bit calm_sender   = 1'b0;
    bit hold_req      = 1'b0;           // sender is about to stream a whole phase

    // base64 alphabet lookup: bit 6 flags a symbol, bits 5:0 its value
    function automatic logic [6:0] base64_value(input logic [7:0] c);
        logic [6:0] r;
        r = '0;
        if (c >= "A" && c <= "Z")
            r = {1'b1, 6'(c - "A")};
        else if (c >= "a" && c <= "z")
            r = {1'b1, 6'(c - "a" + 8'd26)};
        else if (c >= "0" && c <= "9")
            r = {1'b1, 6'(c - "0" + 8'd52)};
        else if (c == CH_PLUS)
            r = {1'b1, 6'd62};
        else if (c == CH_SLASH)
            r = {1'b1, 6'd63};
        return r;
    endfunction

    function automatic logic [7:0] symbol_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26)
            c = "A" + 8'(v);
        else if (v < 6'd52)
            c = "a" + 8'(v - 6'd26);
        else if (v < 6'd62)
            c = "0" + 8'(v - 6'd52);
        else if (v == 6'd62)
            c = CH_PLUS;
        else
            c = CH_SLASH;
        return c;
    endfunction

    function automatic logic [7:0] any_but_lf();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CH_LF)
            c = CH_DASH;
        return c;
    endfunction

    function automatic logic [7:0] blank_char();
        logic [7:0] c;
        case ($urandom_range(0, 2))
            0:       c = CH_SP;
            1:       c = CH_CR;
            default: c = CH_TAB;
        endcase
        return c;
    endfunction

    // one decoded byte, unless an error is latched or capacity is used up
    task automatic push_byte(input logic [7:0] b);
        if (fault == ST_OK)
        begin
            if (emitted >= capacity)
                fault = ST_OVERFLOW;
            else
            begin
                if (emitted != 16'hFFFF)
                    emitted++;
                step_q.push_back('{data_byte: b, has_data: 1'b1, run_last: 1'b0,
                                   message_end: 1'b0, status: ST_OK, byte_count: emitted});
            end
        end
    endtask

    // one symbol or pad into the four-symbol group
    task automatic absorb_symbol(input logic [5:0] s, input logic is_pad);
        logic [23:0] v;
        int          n;
        if (fault == ST_OK)
        begin
            case (group_pos)
                2'd0:
                begin
                    if (is_pad)
                        fault = ST_BAD_PAD;
                    else
                    begin
                        accum = {12'd0, s};
                        group_pos = 2'd1;
                    end
                end
                2'd1:
                begin
                    if (is_pad)
                        fault = ST_BAD_PAD;
                    else
                    begin
                        accum = {accum[11:0], s};
                        group_pos = 2'd2;
                    end
                end
                2'd2:
                begin
                    if (is_pad)
                    begin
                        pad3 = 1'b1;
                        accum = {accum[11:0], 6'd0};
                    end
                    else
                        accum = {accum[11:0], s};
                    group_pos = 2'd3;
                end
                default:
                begin
                    // a pad in the third slot needs a pad in the fourth
                    if (pad3 && !is_pad)
                        fault = ST_BAD_PAD;
                    else
                    begin
                        v = {accum, is_pad ? 6'd0 : s};
                        n = pad3 ? 1 : (is_pad ? 2 : 3);
                        push_byte(v[23:16]);
                        if (n >= 2)
                            push_byte(v[15:8]);
                        if (n >= 3)
                            push_byte(v[7:0]);
                        group_pos = 2'd0;
                        pad3 = 1'b0;
                        accum = '0;
                    end
                end
            endcase
        end
    endtask

    // model one accepted character and queue the results it causes
    task automatic decode_char(input logic [7:0] c, input logic last);
        logic        go;
        logic [6:0]  sym;
        pem_result_t r;
        go = 1'b1;
        if (c == CH_LF)
        begin
            line_start = 1'b1;
            skipping = 1'b0;
            go = 1'b0;
        end
        else if (line_start)
        begin
            // only the very first character of a line can start a header line
            line_start = 1'b0;
            if (c == CH_DASH)
            begin
                skipping = 1'b1;
                go = 1'b0;
            end
        end
        else if (skipping)
            go = 1'b0;
        if (go && !(c == CH_SP || c == CH_CR || c == CH_TAB))
        begin
            sym = base64_value(c);
            if (c == CH_PAD)
                absorb_symbol(6'd0, 1'b1);
            else if (sym[6])
                absorb_symbol(sym[5:0], 1'b0);
            else if (fault == ST_OK)
                fault = ST_BAD_CHAR;
        end
        if (last)
        begin
            // pad out a partial group, then report and start over
            while (group_pos != 2'd0 && fault == ST_OK)
                absorb_symbol(6'd0, 1'b1);
            step_q.push_back('{data_byte: 8'd0, has_data: 1'b0, run_last: 1'b0,
                               message_end: 1'b1, status: fault, byte_count: emitted});
            line_start = 1'b1;
            skipping = 1'b0;
            accum = '0;
            group_pos = '0;
            pad3 = 1'b0;
            fault = ST_OK;
            emitted = '0;
        end
        if (step_q.size() > 0)
        begin
            r = step_q.pop_back();
            r.run_last = 1'b1;
            step_q.push_back(r);
        end
        while (step_q.size() > 0)
            pending_results.push_back(step_q.pop_front());
    endtask

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // offer one character, with random gaps, and model it on acceptance
    task automatic send_char(input logic [7:0] ch, input logic last);
        while (!calm_sender && $urandom_range(0, 99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        decode_char(ch, last);
        chars_sent++;
    endtask

    // let the block go quiet, then change out_capacity
    task automatic write_capacity(input logic [15:0] cap);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        capacity = cap;
        cap_settings++;
    endtask

    // build one random pem message into msg_chars
    task automatic compose_message();
        int         kind;
        int         nsym;
        int         i;
        int         j;
        int         ps;
        int         r;
        logic [7:0] body[$];
        msg_chars.delete();
        kind = $urandom_range(0, 9);
        // optional header line, any content up to the lf
        if ($urandom_range(0, 9) < 6)
        begin
            msg_chars.push_back(CH_DASH);
            r = $urandom_range(0, 5);
            for (j = 0; j < r; j++)
                msg_chars.push_back(any_but_lf());
            msg_chars.push_back(CH_LF);
        end
        if (kind == 9)
        begin
            // raw noise
            r = $urandom_range(1, 8);
            for (j = 0; j < r; j++)
                body.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            nsym = $urandom_range(0, 14);
            i = 0;
            while (i < nsym)
            begin
                // now and then a padded group in the middle of the data
                if (i % 4 == 0 && nsym - i >= 4 && $urandom_range(0, 9) == 0)
                begin
                    ps = $urandom_range(2, 3);
                    for (j = 0; j < ps; j++)
                        body.push_back(symbol_char(6'($urandom_range(0, 63))));
                    for (j = ps; j < 4; j++)
                        body.push_back(CH_PAD);
                    i += 4;
                end
                else
                begin
                    body.push_back(symbol_char(6'($urandom_range(0, 63))));
                    i++;
                end
                r = $urandom_range(0, 99);
                if (r < 8)
                    body.push_back(blank_char());
                else if (r < 13)
                    body.push_back(CH_LF);
            end
            // explicit padding half the time, otherwise the block pads at the end
            if ($urandom_range(0, 1))
            begin
                if (nsym % 4 == 2)
                begin
                    body.push_back(CH_PAD);
                    body.push_back(CH_PAD);
                end
                else if (nsym % 4 == 3)
                    body.push_back(CH_PAD);
            end
            if (kind == 7 && body.size() > 0)
                body[$urandom_range(0, body.size() - 1)] = 8'($urandom_range(0, 255));
            if (kind == 8)
                body.insert($urandom_range(0, body.size()), CH_PAD);
        end
        foreach (body[k])
            msg_chars.push_back(body[k]);
        // optional footer line
        if ($urandom_range(0, 9) < 4)
        begin
            msg_chars.push_back(CH_LF);
            msg_chars.push_back(CH_DASH);
            r = $urandom_range(0, 4);
            for (j = 0; j < r; j++)
                msg_chars.push_back(any_but_lf());
        end
        if (msg_chars.size() == 0)
            msg_chars.push_back(CH_LF);
    endtask

    // directed rows: empty message, nul, early pad, header skip, pad in third only,
    // dash after leading blank, top code, alphabet edges, partial groups
    stim_row_t directed_rows [N_DIRECTED] = '{
        '{CH_LF,    1'b1, 1'b1, ST_OK,       16'd0},
        '{CH_NUL,   1'b1, 1'b1, ST_BAD_CHAR, 16'd0},
        '{CH_PAD,   1'b1, 1'b1, ST_BAD_PAD,  16'd0},
        '{CH_DASH,  1'b0, 1'b0, ST_OK,       16'd0},
        '{"x",      1'b0, 1'b0, ST_OK,       16'd0},
        '{CH_LF,    1'b0, 1'b0, ST_OK,       16'd0},
        '{"T",      1'b0, 1'b0, ST_OK,       16'd0},
        '{"W",      1'b0, 1'b0, ST_OK,       16'd0},
        '{"F",      1'b0, 1'b0, ST_OK,       16'd0},
        '{"u",      1'b0, 1'b0, ST_OK,       16'd0},
        '{CH_SP,    1'b1, 1'b1, ST_OK,       16'd3},
        '{"Q",      1'b0, 1'b0, ST_OK,       16'd0},
        '{"Q",      1'b0, 1'b0, ST_OK,       16'd0},
        '{CH_PAD,   1'b0, 1'b0, ST_OK,       16'd0},
        '{"A",      1'b1, 1'b1, ST_BAD_PAD,  16'd0},
        '{CH_SP,    1'b0, 1'b0, ST_OK,       16'd0},
        '{CH_DASH,  1'b1, 1'b1, ST_BAD_CHAR, 16'd0},
        '{8'hFF,    1'b1, 1'b1, ST_BAD_CHAR, 16'd0},
        '{CH_SLASH, 1'b0, 1'b0, ST_OK,       16'd0},
        '{CH_PLUS,  1'b0, 1'b0, ST_OK,       16'd0},
        '{"z",      1'b0, 1'b0, ST_OK,       16'd0},
        '{CH_TAB,   1'b1, 1'b1, ST_OK,       16'd2},
        '{"A",      1'b0, 1'b0, ST_OK,       16'd0},
        '{"0",      1'b0, 1'b0, ST_OK,       16'd0},
        '{CH_CR,    1'b1, 1'b1, ST_OK,       16'd1}
    };

    // main sequence: reset, directed rows, then random messages per capacity setting
    initial
    begin
        pem_result_t r;
        logic [15:0] cap;
        int          phase;
        int          phase_items;
        int          random_items;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_char(directed_rows[i].ch, directed_rows[i].last);
            // status transfer of a typed row takes the table's values
            if (directed_rows[i].typed)
            begin
                r = pending_results.pop_back();
                r.status = directed_rows[i].st;
                r.byte_count = directed_rows[i].cnt;
                pending_results.push_back(r);
            end
        end
        messages_sent += 9;

        random_items = 0;
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            case (phase)
                0:       cap = CAP_RESET;
                1:       cap = 16'd0;
                2:       cap = 16'd1;
                3:       cap = 16'd3;
                4:       cap = 16'($urandom_range(2, 12));
                5:       cap = 16'($urandom_range(0, 65535));
                6:       cap = 16'($urandom_range(4, 20));
                default: cap = CAP_RESET;
            endcase
            write_capacity(cap);
            // the receiver starts its one long stall as this phase is offered
            if (phase == 0)
                hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                compose_message();
                foreach (msg_chars[k])
                begin
                    // a stretch of back-to-back characters
                    calm_sender = (random_items >= 120 && random_items < 180);
                    send_char(msg_chars[k], k == msg_chars.size() - 1);
                    random_items++;
                end
                phase_items += msg_chars.size();
                messages_sent++;
            end
        end

        // drain, then wait out the settle time for anything stray
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb: %0d characters in %0d messages over %0d capacity settings",
                 chars_sent, messages_sent, cap_settings);
        $display("tb: %0d output transfers, %0d decoded bytes and %0d statuses, %0d with an error",
                 results_seen, bytes_checked, status_seen, faults_seen);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ---------------------------------------------------------------
    // receiver side
    // ---------------------------------------------------------------

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            failures++;
        end
    endtask

    // compare one output transfer with the oldest expectation
    task automatic check_result(input pem_result_t got);
        pem_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected output transfer: data %0h user %0h", got.data_byte,
                   {got.message_end, got.has_data});
            failures++;
        end
        else
        begin
            want = pending_results.pop_front();
            compare_field("data_byte",   want.data_byte,   got.data_byte);
            compare_field("has_data",    want.has_data,    got.has_data);
            compare_field("run_last",    want.run_last,    got.run_last);
            compare_field("message_end", want.message_end, got.message_end);
            compare_field("status",      want.status,      got.status);
            compare_field("byte_count",  want.byte_count,  got.byte_count);
        end
    endtask

    // samples transfers at each edge and picks the next m_tready
    initial
    begin
        pem_result_t got;
        int          cycle_no;
        int          hold_left;
        bit          held;
        logic        next_ready;
        cycle_no  = 0;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (m_tvalid && m_tready)
            begin
                got.data_byte   = m_tdata[7:0];
                got.status      = m_tdata[9:8];
                got.byte_count  = m_tdata[25:10];
                got.run_last    = m_tlast;
                got.has_data    = m_tuser[0];
                got.message_end = m_tuser[1];
                check_result(got);
                results_seen++;
                if (got.has_data)
                    bytes_checked++;
                if (got.message_end)
                begin
                    status_seen++;
                    if (got.status != ST_OK)
                        faults_seen++;
                end
            end
            // one long stall while the sender keeps offering, so the input backs up
            if (!held && hold_req)
            begin
                held = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_ready = 1'b0;
            end
            else if (cycle_no >= 700 && cycle_no < 1000)
                next_ready = 1'b1;
            else
                next_ready = ($urandom_range(0, 99) >= IDLE_PCT);
            m_tready <= next_ready;
        end
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
